@@ hw/rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, codes and packing widths shared by the i2c master modules
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START, PH_RSTART, PH_S_ADW, PH_S_REG, PH_S_ADR, PH_S_DAT,
        PH_A_ADW, PH_A_REG, PH_A_ADR, PH_A_DAT, PH_READ, PH_RACK, PH_STOP
    } phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK_DEV = 2'd1;
    localparam logic [1:0] ST_NACK_REG = 2'd2;
    localparam logic [1:0] ST_NACK_DAT = 2'd3;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_HALF_PER = 1'b1;

    typedef struct packed {
        logic       go;
        logic       req_type;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       data_take;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } res_t;

    localparam int QDEPTH = 2;

endpackage

@@ hw/rtl/i2cm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// input item unpacking and a two-entry queue toward the sequencer
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_data,
    input  logic        in_user,
    output logic        q_valid,
    input  logic        q_ready,
    output tick_t       q_item
);

    tick_t      mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    tick_t      item;
    logic       push, pop;

    always_comb
    begin
        item.go          = in_data[0];
        item.req_type    = in_data[1];
        item.reg_address = in_data[9:2];
        item.byte_count  = in_data[17:10];
        item.write_byte  = in_data[25:18];
        item.sda_in      = in_user;
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/i2cm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_seq
// bus sequencer: one tick per item, result held in an output register
// ----------------------------------------------------------------------------
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  tick_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  lreg_reg, lreg_next;
    logic        kind_reg, kind_next;
    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  fail_reg, fail_next;
    logic [6:0]  dev_reg;
    logic [15:0] half_reg;
    logic        ov_reg;
    res_t        res_reg, r;
    logic        step;
    phase_t      ph;
    logic [15:0] h;

    assign q_ready   = !ov_reg || out_ready;
    assign step      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        tick_next  = tick_reg;
        lreg_next  = lreg_reg;
        kind_next  = kind_reg;
        sub_next   = sub_reg;
        fail_next  = fail_reg;
        r          = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        h = (half_reg == 16'd0) ? 16'd1 : half_reg;
        if (phase_reg == PH_IDLE && q_item.go)
        begin
            kind_next  = q_item.req_type;
            lreg_next  = q_item.reg_address;
            left_next  = q_item.byte_count;
            fail_next  = ST_OK;
            phase_next = PH_START;
            sub_next   = 2'd0;
            bit_next   = 3'd0;
            tick_next  = 16'd0;
        end
        ph = phase_next;
        if (ph != PH_IDLE)
        begin
            r.busy_res = 1'b1;
            case (ph)
                PH_START, PH_RSTART: r.sda_level = (sub_next == 2'd0);
                PH_S_ADW, PH_S_REG, PH_S_ADR, PH_S_DAT:
                begin
                    if (sub_next == 2'd0)
                    begin
                        r.scl_level = 1'b0;
                        r.sda_level = !(ph == PH_S_ADW || ph == PH_S_ADR);
                    end
                    else
                    begin
                        r.scl_level = (sub_next == 2'd2);
                        r.sda_level = shift_next[7];
                    end
                end
                PH_A_ADW, PH_A_REG, PH_A_ADR, PH_A_DAT: r.scl_level = (sub_next == 2'd0);
                PH_READ: r.scl_level = (sub_next == 2'd1 || sub_next == 2'd2);
                PH_RACK:
                begin
                    r.scl_level = (sub_next == 2'd2);
                    r.sda_level = (sub_next == 2'd0) ? 1'b1 : !(left_next > 8'd1);
                end
                PH_STOP:
                begin
                    r.scl_level = (sub_next != 2'd0);
                    r.sda_level = 1'b0;
                end
                default: ;
            endcase
            if (17'(tick_next) + 17'd1 >= 17'(h))
            begin
                tick_next = 16'd0;
                case (ph)
                    PH_START, PH_RSTART:
                    begin
                        if (sub_next == 2'd0)
                        begin
                            sub_next = 2'd1;
                        end
                        else
                        begin
                            phase_next = (ph == PH_START) ? PH_S_ADW : PH_S_ADR;
                            sub_next   = 2'd0;
                            bit_next   = 3'd0;
                            shift_next = {dev_reg, ph == PH_RSTART};
                        end
                    end
                    PH_S_ADW, PH_S_REG, PH_S_ADR, PH_S_DAT:
                    begin
                        if (sub_next != 2'd3)
                        begin
                            sub_next = sub_next + 2'd1;
                        end
                        else
                        begin
                            shift_next = {shift_next[6:0], 1'b0};
                            if (bit_next == 3'd7)
                            begin
                                phase_next = phase_t'(5'(ph) + 5'd4);
                                sub_next   = 2'd0;
                                bit_next   = 3'd0;
                            end
                            else
                            begin
                                bit_next = bit_next + 3'd1;
                                sub_next = 2'd1;
                            end
                        end
                    end
                    PH_A_ADW, PH_A_REG, PH_A_ADR, PH_A_DAT:
                    begin
                        if (sub_next == 2'd0)
                        begin
                            if (q_item.sda_in)
                            begin
                                fail_next = (ph == PH_A_REG) ? ST_NACK_REG :
                                            (ph == PH_A_DAT) ? ST_NACK_DAT : ST_NACK_DEV;
                                phase_next = PH_STOP;
                                sub_next   = 2'd0;
                            end
                            else
                            begin
                                sub_next = 2'd1;
                            end
                        end
                        else if (ph == PH_A_ADW)
                        begin
                            phase_next = PH_S_REG;
                            sub_next   = 2'd0;
                            bit_next   = 3'd0;
                            shift_next = lreg_next;
                        end
                        else if (ph == PH_A_REG && kind_next)
                        begin
                            phase_next = PH_RSTART;
                            sub_next   = 2'd0;
                        end
                        else if (left_next == 8'd0)
                        begin
                            phase_next = PH_STOP;
                            sub_next   = 2'd0;
                        end
                        else if (ph == PH_A_ADR)
                        begin
                            phase_next = PH_READ;
                            sub_next   = 2'd0;
                            bit_next   = 3'd0;
                            shift_next = 8'd0;
                        end
                        else
                        begin
                            r.data_take = 1'b1;
                            left_next  = left_next - 8'd1;
                            phase_next = PH_S_DAT;
                            sub_next   = 2'd0;
                            bit_next   = 3'd0;
                            shift_next = q_item.write_byte;
                        end
                    end
                    PH_READ:
                    begin
                        if (sub_next == 2'd1)
                        begin
                            shift_next = {shift_next[6:0], q_item.sda_in};
                        end
                        if (sub_next != 2'd3)
                        begin
                            sub_next = sub_next + 2'd1;
                        end
                        else if (bit_next == 3'd7)
                        begin
                            r.read_valid = 1'b1;
                            r.read_byte  = shift_next;
                            r.read_last  = (left_next == 8'd1);
                            phase_next   = PH_RACK;
                            sub_next     = 2'd0;
                            bit_next     = 3'd0;
                        end
                        else
                        begin
                            bit_next = bit_next + 3'd1;
                            sub_next = 2'd1;
                        end
                    end
                    PH_RACK:
                    begin
                        if (sub_next != 2'd2)
                        begin
                            sub_next = sub_next + 2'd1;
                        end
                        else
                        begin
                            left_next = left_next - 8'd1;
                            sub_next  = 2'd0;
                            if (left_next != 8'd0)
                            begin
                                phase_next = PH_READ;
                                bit_next   = 3'd0;
                                shift_next = 8'd0;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                    end
                    PH_STOP:
                    begin
                        if (sub_next == 2'd0)
                        begin
                            sub_next = 2'd1;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            r.status   = fail_next;
                            fail_next  = ST_OK;
                            phase_next = PH_IDLE;
                            sub_next   = 2'd0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        sub_next   = 2'd0;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_next + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            left_reg  <= 8'd0;
            tick_reg  <= 16'd0;
            lreg_reg  <= 8'd0;
            kind_reg  <= 1'b0;
            sub_reg   <= 2'd0;
            fail_reg  <= ST_OK;
            dev_reg   <= 7'd18;
            half_reg  <= 16'd40;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                tick_reg  <= tick_next;
                lreg_reg  <= lreg_next;
                kind_reg  <= kind_next;
                sub_reg   <= sub_next;
                fail_reg  <= fail_next;
            end
            if (step)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == CFG_DEV_ADDR)
            begin
                dev_reg <= cfg_data[6:0];
            end
            if (cfg_we && cfg_index == CFG_HALF_PER)
            begin
                half_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/i2c_master_register_transfer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// register-addressed i2c burst master, one input item per bus tick
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   tick item: go, req_type, reg_address, byte_count, write_byte
// m_axis   out  line drives, data_take, read byte, busy/done/status
// cfg      in   0 device_address, 1 half_period_ticks
// one item per cycle unless output stalls; each item is one step of the sequencer
// two-entry input queue, result held in an output register
// rst_n clears state to idle, address 18, half period 40
// a stalled output holds the sequencer; the queue then fills and drops tready
// ----------------------------------------------------------------------------
module i2c_master_register_transfer
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // go, req_type, reg_address, byte_count, write_byte
    input  logic        s_axis_tuser,  // sda_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // scl, sda, data_take, read_byte, read_valid,
                                       // busy_res, done_res, status
    output logic        m_axis_tlast   // read_last
);

    logic  q_valid, q_ready;
    tick_t q_item;
    res_t  res;

    i2cm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.status, res.done_res, res.busy_res, res.read_valid,
                           res.read_byte, res.data_take, res.sda_level, res.scl_level};
    assign m_axis_tlast = res.read_last;

endmodule
